/* hdl/mips_trap_return_pc_resolver_unit_assert.svh */
// ----------------------------------------------------------------------------
// mips trap return pc resolver assertion macros
// shared concurrent assertion forms, clocked on i_clk, held off during reset
// ----------------------------------------------------------------------------
`ifndef MIPS_TRAP_RETURN_PC_RESOLVER_UNIT_ASSERT_SVH
`define MIPS_TRAP_RETURN_PC_RESOLVER_UNIT_ASSERT_SVH

// same-cycle implication
`define MTRPR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("assertion failed: same-cycle check");

// next-cycle implication
`define MTRPR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("assertion failed: next-cycle check");

`endif

/* hdl/mtrpr_pkg.sv */
// ----------------------------------------------------------------------------
// mtrpr_pkg
// types and constants of the trap return pc resolver
// ----------------------------------------------------------------------------
package mtrpr_pkg;

    localparam logic [4:0] EC_INTERRUPT = 5'd0;
    localparam logic [4:0] EC_SYSCALL   = 5'd8;
    localparam logic [4:0] EC_BREAK     = 5'd9;

    localparam logic [5:0] OP_FUNCT_GROUP = 6'd0;
    localparam logic [5:0] OP_RT_GROUP    = 6'd1;
    localparam logic [5:0] OP_J           = 6'd2;
    localparam logic [5:0] OP_JAL         = 6'd3;
    localparam logic [5:0] OP_BEQ         = 6'd4;
    localparam logic [5:0] OP_BNE         = 6'd5;
    localparam logic [5:0] OP_BLEZ        = 6'd6;
    localparam logic [5:0] OP_BGTZ        = 6'd7;
    localparam logic [5:0] OP_BEQL        = 6'd20;
    localparam logic [5:0] OP_BNEL        = 6'd21;
    localparam logic [5:0] OP_BLEZ_LIKELY = 6'd22;
    localparam logic [5:0] OP_BGTZ_LIKELY = 6'd23;

    localparam logic [5:0] FN_JR   = 6'd8;
    localparam logic [5:0] FN_JALR = 6'd9;

    localparam logic [4:0] RT_BLTZ    = 5'd0;
    localparam logic [4:0] RT_BGEZ    = 5'd1;
    localparam logic [4:0] RT_BLTZL   = 5'd2;
    localparam logic [4:0] RT_BGEZL   = 5'd3;
    localparam logic [4:0] RT_BLTZAL  = 5'd16;
    localparam logic [4:0] RT_BGEZAL  = 5'd17;
    localparam logic [4:0] RT_BLTZALL = 5'd18;
    localparam logic [4:0] RT_BGEZALL = 5'd19;

    localparam logic [4:0]  LINK_REG  = 5'd31;
    localparam logic [63:0] STEP_NEXT = 64'd4;
    localparam logic [63:0] STEP_PAST = 64'd8;

    typedef enum logic [2:0] {
        OUT_SYSCALL    = 3'd0,
        OUT_BREAKPOINT = 3'd1,
        OUT_INTERRUPT  = 3'd2,
        OUT_UNEXPECTED = 3'd3,
        OUT_NOT_BRANCH = 3'd4
    } t_outcome;

    typedef enum logic [2:0] {
        SEL_PC    = 3'd0,
        SEL_PC4   = 3'd1,
        SEL_PC8   = 3'd2,
        SEL_RS    = 3'd3,
        SEL_JUMP  = 3'd4,
        SEL_TAKEN = 3'd5
    } t_sel;

    typedef struct packed {
        t_outcome   outcome;
        t_sel       sel;
        logic       link_valid;
        logic [4:0] link_index;
    } t_dec;

endpackage

/* hdl/mtrpr_if.sv */
// ----------------------------------------------------------------------------
// mtrpr_if
// valid/ready channels for trap transactions and resolved results
// ----------------------------------------------------------------------------
interface mtrpr_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] cause_word;
    logic [63:0] victim_pc;
    logic [31:0] instruction_word;
    logic signed [63:0] rs_value;
    logic signed [63:0] rt_value;

    modport source (
        output valid, cause_word, victim_pc, instruction_word, rs_value, rt_value,
        input  ready
    );
    modport sink (
        input  valid, cause_word, victim_pc, instruction_word, rs_value, rt_value,
        output ready
    );
endinterface

interface mtrpr_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] resume_pc;
    logic [2:0]  outcome;
    logic        link_valid;
    logic [4:0]  link_index;
    logic [63:0] link_value;

    modport source (
        output valid, resume_pc, outcome, link_valid, link_index, link_value,
        input  ready
    );
    modport sink (
        input  valid, resume_pc, outcome, link_valid, link_index, link_value,
        output ready
    );
endinterface

/* hdl/mips_trap_return_pc_resolver_unit.sv */
// ----------------------------------------------------------------------------
// mips_trap_return_pc_resolver_unit
// resolves the return pc and link write of a trap, three-stage pipeline
//
//  channel   direction  handshake      payload
//  i_trap    in         valid/ready    cause, epc, instruction, rs, rt values
//  o_res     out        valid/ready    resume pc, outcome, link write
//
//  one transaction per cycle sustained while o_res is ready
//  stage 1 decodes and compares, stage 2 forms pc+4, pc+8 and pc+offset,
//  stage 3 adds the delay-slot step to the branch target and selects
//  a stage advances when empty or when the stage after it advances, the last one when o_res is ready
//  synchronous active-low reset clears the stage valid bits only
// ----------------------------------------------------------------------------
`include "mips_trap_return_pc_resolver_unit_assert.svh"

module mips_trap_return_pc_resolver_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mtrpr_in_if.sink    i_trap,
    mtrpr_out_if.source o_res
);
    import mtrpr_pkg::*;

    t_dec dec;

    logic        r_v1;
    t_dec        r_s1_dec;
    logic [63:0] r_s1_pc;
    logic [63:0] r_s1_rs;
    logic [25:0] r_s1_idx;

    logic        r_v2;
    t_dec        r_s2_dec;
    logic [63:0] r_s2_pc;
    logic [63:0] r_s2_pc4;
    logic [63:0] r_s2_pc8;
    logic [63:0] r_s2_pcoff;
    logic [63:0] r_s2_rs;
    logic [25:0] r_s2_idx;

    logic        r_v3;
    logic [63:0] r_resume_pc;
    t_outcome    r_outcome;
    logic        r_link_valid;
    logic [4:0]  r_link_index;
    logic [63:0] r_link_value;

    logic        adv1;
    logic        adv2;
    logic        adv3;
    logic [63:0] off;
    logic [63:0] n_resume_pc;

    assign adv3 = !r_v3 || o_res.ready;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;
    assign i_trap.ready = adv1;

    mtrpr_decode u_decode (
        .i_cause_word       (i_trap.cause_word),
        .i_instruction_word (i_trap.instruction_word),
        .i_rs_value         (i_trap.rs_value),
        .i_rt_value         (i_trap.rt_value),
        .o_dec              (dec)
    );

    assign off = {{46{r_s1_idx[15]}}, r_s1_idx[15:0], 2'b00};

    always_comb begin
        unique case (r_s2_dec.sel)
            SEL_PC:    n_resume_pc = r_s2_pc;
            SEL_PC4:   n_resume_pc = r_s2_pc4;
            SEL_PC8:   n_resume_pc = r_s2_pc8;
            SEL_RS:    n_resume_pc = r_s2_rs;
            SEL_JUMP:  n_resume_pc = {r_s2_pc4[63:28], r_s2_idx, 2'b00};
            SEL_TAKEN: n_resume_pc = r_s2_pcoff + STEP_NEXT;
            default:   n_resume_pc = r_s2_pc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_trap.valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s1_dec <= dec;
            r_s1_pc  <= i_trap.victim_pc;
            r_s1_rs  <= i_trap.rs_value;
            r_s1_idx <= i_trap.instruction_word[25:0];
        end
        if (adv2) begin
            r_s2_dec   <= r_s1_dec;
            r_s2_pc    <= r_s1_pc;
            r_s2_pc4   <= r_s1_pc + STEP_NEXT;
            r_s2_pc8   <= r_s1_pc + STEP_PAST;
            r_s2_pcoff <= r_s1_pc + off;
            r_s2_rs    <= r_s1_rs;
            r_s2_idx   <= r_s1_idx;
        end
        if (adv3) begin
            r_resume_pc  <= n_resume_pc;
            r_outcome    <= r_s2_dec.outcome;
            r_link_valid <= r_s2_dec.link_valid;
            r_link_index <= r_s2_dec.link_valid ? r_s2_dec.link_index : 5'd0;
            r_link_value <= r_s2_dec.link_valid ? r_s2_pc8 : 64'd0;
        end
    end

    assign o_res.valid      = r_v3;
    assign o_res.resume_pc  = r_resume_pc;
    assign o_res.outcome    = r_outcome;
    assign o_res.link_valid = r_link_valid;
    assign o_res.link_index = r_link_index;
    assign o_res.link_value = r_link_value;

    `MTRPR_ASSERT_NEXT(a_accept_fills_s1, i_trap.valid && i_trap.ready, r_v1)
    `MTRPR_ASSERT_NEXT(a_held_result_stays, r_v3 && !o_res.ready, r_v3)
    `MTRPR_ASSERT_NOW(a_no_link_zero, r_v3 && !r_link_valid,
        r_link_index == 5'd0 && r_link_value == 64'd0)
    `MTRPR_ASSERT_NOW(a_link_only_skipped, r_v3 && r_link_valid,
        r_outcome == OUT_SYSCALL || r_outcome == OUT_BREAKPOINT)

endmodule

/* hdl/mtrpr_decode.sv */
// ----------------------------------------------------------------------------
// mtrpr_decode
// trap classification and branch/jump decode with condition evaluation
// ----------------------------------------------------------------------------
module mtrpr_decode (
    input  logic [31:0]        i_cause_word,
    input  logic [31:0]        i_instruction_word,
    input  logic signed [63:0] i_rs_value,
    input  logic signed [63:0] i_rt_value,
    output mtrpr_pkg::t_dec    o_dec
);
    import mtrpr_pkg::*;

    logic [4:0] code;
    logic       bd;
    logic [5:0] op;
    logic [4:0] rtf;
    logic [4:0] rdf;
    logic [5:0] fn;
    logic       rs_neg;
    logic       rs_zero;
    logic       rs_eq_rt;
    logic       ok;
    logic       is_cond;
    logic       cond;
    logic       blink;
    logic [4:0] breg;
    t_sel       bsel;

    assign code     = i_cause_word[6:2];
    assign bd       = i_cause_word[31];
    assign op       = i_instruction_word[31:26];
    assign rtf      = i_instruction_word[20:16];
    assign rdf      = i_instruction_word[15:11];
    assign fn       = i_instruction_word[5:0];
    assign rs_neg   = i_rs_value[63];
    assign rs_zero  = (i_rs_value == 64'sd0);
    assign rs_eq_rt = (i_rs_value == i_rt_value);

    always_comb begin
        ok      = 1'b1;
        is_cond = 1'b0;
        cond    = 1'b0;
        blink   = 1'b0;
        breg    = 5'd0;
        bsel    = SEL_PC;
        unique case (op)
            OP_FUNCT_GROUP: begin
                if (fn == FN_JR) begin
                    bsel = SEL_RS;
                end else if (fn == FN_JALR) begin
                    bsel  = SEL_RS;
                    blink = 1'b1;
                    breg  = rdf;
                end else begin
                    ok = 1'b0;
                end
            end
            OP_J: begin
                bsel = SEL_JUMP;
            end
            OP_JAL: begin
                bsel  = SEL_JUMP;
                blink = 1'b1;
                breg  = LINK_REG;
            end
            OP_RT_GROUP: begin
                is_cond = 1'b1;
                unique case (rtf)
                    RT_BLTZ, RT_BLTZL: cond = rs_neg;
                    RT_BGEZ, RT_BGEZL: cond = !rs_neg;
                    RT_BLTZAL, RT_BLTZALL: begin
                        cond  = rs_neg;
                        blink = 1'b1;
                        breg  = LINK_REG;
                    end
                    RT_BGEZAL, RT_BGEZALL: begin
                        cond  = !rs_neg;
                        blink = 1'b1;
                        breg  = LINK_REG;
                    end
                    default: ok = 1'b0;
                endcase
            end
            OP_BEQ, OP_BEQL: begin
                is_cond = 1'b1;
                cond    = rs_eq_rt;
            end
            OP_BNE, OP_BNEL: begin
                is_cond = 1'b1;
                cond    = !rs_eq_rt;
            end
            OP_BLEZ, OP_BLEZ_LIKELY: begin
                is_cond = 1'b1;
                cond    = rs_neg || rs_zero;
            end
            OP_BGTZ, OP_BGTZ_LIKELY: begin
                is_cond = 1'b1;
                cond    = !rs_neg && !rs_zero;
            end
            default: ok = 1'b0;
        endcase
        if (is_cond) begin
            bsel = cond ? SEL_TAKEN : SEL_PC8;
        end

        o_dec.outcome    = OUT_UNEXPECTED;
        o_dec.sel        = SEL_PC;
        o_dec.link_valid = 1'b0;
        o_dec.link_index = 5'd0;
        if (code == EC_SYSCALL || code == EC_BREAK) begin
            o_dec.outcome = (code == EC_SYSCALL) ? OUT_SYSCALL : OUT_BREAKPOINT;
            if (!bd) begin
                o_dec.sel = SEL_PC4;
            end else if (ok) begin
                o_dec.sel        = bsel;
                o_dec.link_valid = blink;
                o_dec.link_index = blink ? breg : 5'd0;
            end else begin
                o_dec.outcome = OUT_NOT_BRANCH;
            end
        end else if (code == EC_INTERRUPT) begin
            o_dec.outcome = OUT_INTERRUPT;
        end
    end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trap return pc resolver testbench
// a short table of hand-picked traps (every branch and jump form, the
// interrupt, skipped and unexpected traps, address wrap, sign extremes)
// followed by random traps, most of them skipped traps in a delay slot;
// both channels idle at random, every result is checked against its table entry
// or an in-bench resolver of the trap, in order, field by field
// ----------------------------------------------------------------------------
module testbench;
    import mtrpr_pkg::*;

    localparam int          RANDOM_TRAPS = 1225;
    localparam int          CYCLE_LIMIT  = 600_000;
    localparam int          SETTLE       = 8;
    localparam logic [31:0] CAUSE_BD     = 32'h8000_0000;
    localparam logic [31:0] CAUSE_INT    = {25'd0, EC_INTERRUPT, 2'b00};
    localparam logic [31:0] CAUSE_SYS    = {25'd0, EC_SYSCALL, 2'b00};
    localparam logic [31:0] CAUSE_BP     = {25'd0, EC_BREAK, 2'b00};
    localparam logic [63:0] S64_MIN      = 64'h8000_0000_0000_0000;
    localparam logic [63:0] S64_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [31:0]        cause_word;
        logic [63:0]        victim_pc;
        logic [31:0]        instruction_word;
        logic signed [63:0] rs_value;
        logic signed [63:0] rt_value;
    } t_trap;

    typedef struct packed {
        logic [63:0] resume_pc;
        t_outcome    outcome;
        logic        link_valid;
        logic [4:0]  link_index;
        logic [63:0] link_value;
    } t_result;

    typedef struct {
        t_trap   stim;
        bit      typed;
        t_result want;
    } t_row;

    logic    i_clk;
    logic    i_rst_n;
    t_result pending_resumes[$];
    int      mismatch_count;
    int      cycle_count;
    t_row    directed_rows[26];

    mtrpr_in_if  trap_if ();
    mtrpr_out_if res_if ();

    mips_trap_return_pc_resolver_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_trap  (trap_if.sink),
        .o_res   (res_if.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic t_result resolve_trap(input t_trap tr);
        t_result     r;
        logic [4:0]  code;
        logic [5:0]  opc;
        logic [4:0]  rt_f;
        logic [5:0]  fn;
        logic [63:0] pc4;
        logic [63:0] fall;
        logic [63:0] taken;
        logic [63:0] target;
        logic [63:0] rsv;
        logic        is_branch;
        logic        link;
        logic [4:0]  link_reg;
        r           = '0;
        r.resume_pc = tr.victim_pc;
        code        = tr.cause_word[6:2];
        opc         = tr.instruction_word[31:26];
        rt_f        = tr.instruction_word[20:16];
        fn          = tr.instruction_word[5:0];
        rsv         = tr.rs_value;
        pc4         = tr.victim_pc + STEP_NEXT;
        fall        = tr.victim_pc + STEP_PAST;
        taken       = pc4 + {{46{tr.instruction_word[15]}}, tr.instruction_word[15:0], 2'b00};
        target      = fall;
        is_branch   = 1'b1;
        link        = 1'b0;
        link_reg    = LINK_REG;
        if (code == EC_SYSCALL || code == EC_BREAK) begin
            r.outcome = (code == EC_SYSCALL) ? OUT_SYSCALL : OUT_BREAKPOINT;
            if (!tr.cause_word[31]) begin
                r.resume_pc = pc4;
            end else begin
                case (opc)
                    OP_FUNCT_GROUP: begin
                        is_branch = (fn == FN_JR) || (fn == FN_JALR);
                        target    = rsv;
                        link      = (fn == FN_JALR);
                        link_reg  = tr.instruction_word[15:11];
                    end
                    OP_J, OP_JAL: begin
                        target = {pc4[63:28], tr.instruction_word[25:0], 2'b00};
                        link   = (opc == OP_JAL);
                    end
                    OP_RT_GROUP: begin
                        case (rt_f)
                            RT_BLTZ, RT_BLTZL, RT_BLTZAL, RT_BLTZALL:
                                target = rsv[63] ? taken : fall;
                            RT_BGEZ, RT_BGEZL, RT_BGEZAL, RT_BGEZALL:
                                target = !rsv[63] ? taken : fall;
                            default: is_branch = 1'b0;
                        endcase
                        // the and-link forms sit at rt 16 and up
                        link = rt_f[4];
                    end
                    OP_BEQ, OP_BEQL: target = (rsv == tr.rt_value) ? taken : fall;
                    OP_BNE, OP_BNEL: target = (rsv != tr.rt_value) ? taken : fall;
                    OP_BLEZ, OP_BLEZ_LIKELY:
                        target = ($signed(rsv) <= 0) ? taken : fall;
                    OP_BGTZ, OP_BGTZ_LIKELY:
                        target = ($signed(rsv) > 0) ? taken : fall;
                    default: is_branch = 1'b0;
                endcase
                if (!is_branch) begin
                    r.outcome = OUT_NOT_BRANCH;
                end else begin
                    r.resume_pc = target;
                    if (link) begin
                        r.link_valid = 1'b1;
                        r.link_index = link_reg;
                        r.link_value = fall;
                    end
                end
            end
        end else if (code == EC_INTERRUPT) begin
            r.outcome = OUT_INTERRUPT;
        end else begin
            r.outcome = OUT_UNEXPECTED;
        end
        return r;
    endfunction

    function automatic int draw_wait(inout int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) begin
            quiet_left = $urandom_range(10, 40);
            return 0;
        end
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 18);
    endfunction

    function automatic logic [63:0] random_reg();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return S64_MIN;
            3:       return S64_MAX;
            4:       return 64'($urandom_range(0, 15));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic t_trap random_trap();
        t_trap tr;
        int    pick;
        tr.cause_word       = $urandom;
        tr.victim_pc        = {$urandom, $urandom};
        tr.instruction_word = $urandom;
        tr.rs_value         = random_reg();
        tr.rt_value         = ($urandom_range(0, 2) == 0) ? tr.rs_value : random_reg();
        pick                = $urandom_range(0, 99);
        if (pick < 70) begin
            tr.cause_word[6:2] = $urandom_range(0, 1) ? EC_SYSCALL : EC_BREAK;
            tr.cause_word[31]  = 1'b1;
        end else if (pick < 82) begin
            tr.cause_word[6:2] = $urandom_range(0, 1) ? EC_SYSCALL : EC_BREAK;
            tr.cause_word[31]  = 1'b0;
        end else if (pick < 90) begin
            tr.cause_word[6:2] = EC_INTERRUPT;
        end
        if ($urandom_range(0, 9) == 0) tr.victim_pc[63:4] = '1;
        if ($urandom_range(0, 9) != 0) begin
            case ($urandom_range(0, 11))
                0:  tr.instruction_word[31:26] = OP_FUNCT_GROUP;
                1:  tr.instruction_word[31:26] = OP_RT_GROUP;
                2:  tr.instruction_word[31:26] = OP_J;
                3:  tr.instruction_word[31:26] = OP_JAL;
                4:  tr.instruction_word[31:26] = OP_BEQ;
                5:  tr.instruction_word[31:26] = OP_BNE;
                6:  tr.instruction_word[31:26] = OP_BLEZ;
                7:  tr.instruction_word[31:26] = OP_BGTZ;
                8:  tr.instruction_word[31:26] = OP_BEQL;
                9:  tr.instruction_word[31:26] = OP_BNEL;
                10: tr.instruction_word[31:26] = OP_BLEZ_LIKELY;
                default: tr.instruction_word[31:26] = OP_BGTZ_LIKELY;
            endcase
        end
        if (tr.instruction_word[31:26] == OP_FUNCT_GROUP && $urandom_range(0, 4) != 0)
            tr.instruction_word[5:0] = $urandom_range(0, 1) ? FN_JR : FN_JALR;
        if (tr.instruction_word[31:26] == OP_RT_GROUP && $urandom_range(0, 6) != 0) begin
            case ($urandom_range(0, 7))
                0:       tr.instruction_word[20:16] = RT_BLTZ;
                1:       tr.instruction_word[20:16] = RT_BGEZ;
                2:       tr.instruction_word[20:16] = RT_BLTZL;
                3:       tr.instruction_word[20:16] = RT_BGEZL;
                4:       tr.instruction_word[20:16] = RT_BLTZAL;
                5:       tr.instruction_word[20:16] = RT_BGEZAL;
                6:       tr.instruction_word[20:16] = RT_BLTZALL;
                default: tr.instruction_word[20:16] = RT_BGEZALL;
            endcase
        end
        return tr;
    endfunction

    task automatic send_trap(input t_trap tr, input t_result want, input int gap);
        if (gap > 0) begin
            trap_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        trap_if.valid            <= 1'b1;
        trap_if.cause_word       <= tr.cause_word;
        trap_if.victim_pc        <= tr.victim_pc;
        trap_if.instruction_word <= tr.instruction_word;
        trap_if.rs_value         <= tr.rs_value;
        trap_if.rt_value         <= tr.rt_value;
        do @(posedge i_clk); while (trap_if.ready !== 1'b1);
        pending_resumes.push_back(want);
    endtask

    task automatic await_all_results();
        trap_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_resumes.size() != 0);
    endtask

    task automatic compare_result(input t_result got, input t_result want);
        if (got.resume_pc !== want.resume_pc) begin
            $error("resume_pc mismatch: expected %h, actual %h", want.resume_pc, got.resume_pc);
            mismatch_count++;
        end
        if (got.outcome !== want.outcome) begin
            $error("outcome mismatch: expected %0d, actual %0d", want.outcome, got.outcome);
            mismatch_count++;
        end
        if (got.link_valid !== want.link_valid) begin
            $error("link_valid mismatch: expected %0b, actual %0b",
                   want.link_valid, got.link_valid);
            mismatch_count++;
        end
        if (got.link_index !== want.link_index) begin
            $error("link_index mismatch: expected %0d, actual %0d",
                   want.link_index, got.link_index);
            mismatch_count++;
        end
        if (got.link_value !== want.link_value) begin
            $error("link_value mismatch: expected %h, actual %h",
                   want.link_value, got.link_value);
            mismatch_count++;
        end
    endtask

    // result side
    initial begin
        t_result got;
        int      quiet_left;
        int      stall;
        quiet_left = 0;
        res_if.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            stall = draw_wait(quiet_left);
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (res_if.valid !== 1'b1);
            got.resume_pc  = res_if.resume_pc;
            got.outcome    = t_outcome'(res_if.outcome);
            got.link_valid = res_if.link_valid;
            got.link_index = res_if.link_index;
            got.link_value = res_if.link_value;
            if (pending_resumes.size() == 0) begin
                $error("result transaction with no trap outstanding: resume_pc %h",
                       got.resume_pc);
                mismatch_count++;
            end else begin
                compare_result(got, pending_resumes.pop_front());
            end
        end
    end

    // trap side
    initial begin
        t_trap   tr;
        t_result want;
        int      quiet_left;
        quiet_left = 0;

        directed_rows = '{
            '{'{CAUSE_INT, 64'h1000, 32'h0, 64'h0, 64'h0}, 1'b1,
              '{64'h1000, OUT_INTERRUPT, 1'b0, 5'd0, 64'h0}},
            '{'{CAUSE_BD | CAUSE_INT, '1, '1, '1, '1}, 1'b1,
              '{'1, OUT_INTERRUPT, 1'b0, 5'd0, 64'h0}},
            '{'{CAUSE_SYS, 64'hFFFF_FFFF_FFFF_FFFC, 32'h0, 64'h0, 64'h0}, 1'b1,
              '{64'h0, OUT_SYSCALL, 1'b0, 5'd0, 64'h0}},
            '{'{CAUSE_BP, 64'h0, '1, S64_MIN, S64_MAX}, 1'b1,
              '{64'h4, OUT_BREAKPOINT, 1'b0, 5'd0, 64'h0}},
            '{'{'1, 64'h0123_4567_89AB_CDEF, '1, '1, '1}, 1'b1,
              '{64'h0123_4567_89AB_CDEF, OUT_UNEXPECTED, 1'b0, 5'd0, 64'h0}},
            '{'{CAUSE_BD | CAUSE_SYS, S64_MIN, '1, 64'h0, 64'h0}, 1'b1,
              '{S64_MIN, OUT_NOT_BRANCH, 1'b0, 5'd0, 64'h0}},
            '{'{CAUSE_BD | CAUSE_SYS, 64'hFFFF_FFFF_FFFF_FFFC, {OP_J, 26'h3FF_FFFF},
                64'h0, 64'h0}, 1'b0, '0},
            '{'{CAUSE_BD | CAUSE_BP, 64'h1234_5678_9FFF_FFF8, {OP_JAL, 26'h000_0001},
                64'h0, 64'h0}, 1'b0, '0},
            '{'{CAUSE_BD | CAUSE_SYS, 64'h2000, {OP_FUNCT_GROUP, 5'd31, 15'd0, FN_JR},
                '1, 64'h0}, 1'b0, '0},
            '{'{CAUSE_BD | CAUSE_BP, 64'h100, {OP_FUNCT_GROUP, 5'd2, 15'd0, FN_JALR},
                64'hDEAD_BEEF_0000_0040, 64'h0}, 1'b1,
              '{64'hDEAD_BEEF_0000_0040, OUT_BREAKPOINT, 1'b1, 5'd0, 64'h108}},
            '{'{CAUSE_BD | CAUSE_SYS, 64'h0, {OP_BEQ, 5'd1, 5'd2, 16'h8000},
                64'h5, 64'h5}, 1'b0, '0},
            '{'{CAUSE_BD | CAUSE_SYS, 64'h4000, {OP_BNE, 5'd1, 5'd2, 16'h0010},
                S64_MIN, S64_MIN}, 1'b0, '0},
            '{'{CAUSE_BD | CAUSE_BP, 64'h4000, {OP_BLEZ, 5'd1, 5'd0, 16'h7FFF},
                64'h0, 64'h0}, 1'b0, '0},
            '{'{CAUSE_BD | CAUSE_SYS, 64'h4000, {OP_BGTZ, 5'd1, 5'd0, 16'hFFFF},
                S64_MAX, 64'h0}, 1'b0, '0},
            '{'{CAUSE_BD | CAUSE_BP, 64'h8000, {OP_BEQL, 5'd3, 5'd4, 16'h0020},
                64'h1, 64'h2}, 1'b0, '0},
            '{'{CAUSE_BD | CAUSE_SYS, 64'h8000, {OP_BNEL, 5'd3, 5'd4, 16'h0020},
                S64_MAX, S64_MIN}, 1'b0, '0},
            '{'{CAUSE_BD | CAUSE_BP, 64'h8000, {OP_BLEZ_LIKELY, 5'd3, 5'd0, 16'hFFF0},
                S64_MIN, 64'h0}, 1'b0, '0},
            '{'{CAUSE_BD | CAUSE_SYS, 64'h8000, {OP_BGTZ_LIKELY, 5'd3, 5'd0, 16'h0040},
                64'h0, 64'h0}, 1'b0, '0},
            '{'{CAUSE_BD | CAUSE_SYS, 64'hC000, {OP_RT_GROUP, 5'd4, RT_BLTZ, 16'h0004},
                '1, 64'h0}, 1'b0, '0},
            '{'{CAUSE_BD | CAUSE_BP, 64'hC000, {OP_RT_GROUP, 5'd4, RT_BGEZ, 16'h0004},
                64'h0, 64'h0}, 1'b0, '0},
            '{'{CAUSE_BD | CAUSE_SYS, 64'hC000, {OP_RT_GROUP, 5'd4, RT_BLTZL, 16'h0004},
                S64_MAX, 64'h0}, 1'b0, '0},
            '{'{CAUSE_BD | CAUSE_BP, 64'hC000, {OP_RT_GROUP, 5'd4, RT_BGEZL, 16'h0004},
                S64_MIN, 64'h0}, 1'b0, '0},
            '{'{CAUSE_BD | CAUSE_SYS, 64'hC000, {OP_RT_GROUP, 5'd4, RT_BLTZAL, 16'h0100},
                64'h1, 64'h0}, 1'b0, '0},
            '{'{CAUSE_BD | CAUSE_BP, 64'hC000, {OP_RT_GROUP, 5'd4, RT_BGEZAL, 16'h0100},
                S64_MAX, 64'h0}, 1'b0, '0},
            '{'{CAUSE_BD | CAUSE_SYS, 64'hFFFF_FFFF_FFFF_FFF8,
                {OP_RT_GROUP, 5'd4, RT_BLTZALL, 16'h0100}, S64_MIN, 64'h0}, 1'b0, '0},
            '{'{CAUSE_BD | CAUSE_BP, 64'hC000, {OP_RT_GROUP, 5'd4, RT_BGEZALL, 16'h0100},
                '1, 64'h0}, 1'b0, '0}
        };

        i_rst_n                  <= 1'b0;
        trap_if.valid            <= 1'b0;
        trap_if.cause_word       <= '0;
        trap_if.victim_pc        <= '0;
        trap_if.instruction_word <= '0;
        trap_if.rs_value         <= '0;
        trap_if.rt_value         <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            want = directed_rows[k].typed ? directed_rows[k].want
                                          : resolve_trap(directed_rows[k].stim);
            send_trap(directed_rows[k].stim, want, draw_wait(quiet_left));
        end

        // hold back until the pipeline has emptied
        await_all_results();

        for (int n = 0; n < RANDOM_TRAPS; n++) begin
            tr = random_trap();
            send_trap(tr, resolve_trap(tr), draw_wait(quiet_left));
            if (n % 400 == 399) await_all_results();
        end

        await_all_results();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
